[hw/rtl/subtractive_random_generator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the subtractive random generator
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define SRG_ASSERT_NOW(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define SRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define SRG_ASSERT_NOW(lbl, prop, msg)
`define SRG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/srg_pkg.sv]
// ----------------------------------------------------------------------------
// srg_pkg
// Types, constants and arithmetic helpers of the subtractive random generator.
// ----------------------------------------------------------------------------
package srg_pkg;

    localparam int WORD_BITS = 34;
    localparam int SEED_BITS = 34;
    localparam int IDX_BITS  = 6;
    localparam int TABLE_LEN = 55;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [SEED_BITS-1:0] t_seed;
    typedef logic [IDX_BITS-1:0]  t_idx;

    localparam t_word MODULUS     = t_word'(64'd10070030850);
    localparam t_seed SEED_MOD    = t_seed'(64'd10070030850);
    localparam t_seed SEED_RESET  = t_seed'(64'd127384609);
    localparam t_idx  LAG_START   = t_idx'(31);
    localparam t_idx  IDX_WRAP    = t_idx'(56);
    localparam t_idx  LAST_ADDR   = t_idx'(TABLE_LEN - 1);
    localparam t_idx  FILL_STRIDE = t_idx'(21);
    localparam t_idx  FILL_LAST   = t_idx'(54);

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load_seed;
        logic fill_step;
        logic pass_rd;
        logic pass_wr;
        logic draw_rd;
        logic draw_wr;
    } t_cmd;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic fill_last;
        logic pass_last;
    } t_sts;

    // (a - b) mod MODULUS for operands already below the modulus.
    function automatic t_word mod_sub(input t_word a, input t_word b);
        logic [WORD_BITS:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[WORD_BITS]) begin
            d = d + {1'b0, MODULUS};
        end
        return d[WORD_BITS-1:0];
    endfunction

    // Table indices run 1..55 and wrap back to 1.
    function automatic t_idx next_idx(input t_idx idx);
        t_idx t;
        t = idx + t_idx'(1);
        if (t >= IDX_WRAP || t == t_idx'(0)) begin
            t = t_idx'(1);
        end
        return t;
    endfunction

endpackage

[hw/rtl/srg_req_if.sv]
// ----------------------------------------------------------------------------
// srg_req_if
// Request channel: one beat asks for one draw, optionally reseeding first.
// ----------------------------------------------------------------------------
interface srg_req_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

[hw/rtl/srg_rsp_if.sv]
// ----------------------------------------------------------------------------
// srg_rsp_if
// Response channel: one beat carries one draw.
// ----------------------------------------------------------------------------
interface srg_rsp_if;
    logic                valid;
    logic                ready;
    srg_pkg::t_word      draw;

    modport source (output valid, output draw, input ready);
    modport sink (input valid, input draw, output ready);
endinterface

[hw/rtl/srg_ctrl.sv]
// ----------------------------------------------------------------------------
// srg_ctrl
// Sequencer: table build (fill and four lag passes) and the draw read and write-back.
// ----------------------------------------------------------------------------
module srg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_reseed,
    output logic           o_req_ready,
    input  logic           i_rsp_ready,
    output logic           o_rsp_valid,
    output srg_pkg::t_cmd  o_cmd,
    input  srg_pkg::t_sts  i_sts
);
    import srg_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FILL = 6'b000010,
        S_PRD  = 6'b000100,
        S_PWR  = 6'b001000,
        S_DRD  = 6'b010000,
        S_DWR  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_table_ready, n_table_ready;
    logic   r_rsp_valid, n_rsp_valid;
    t_cmd   cmd;

    always_comb begin
        n_state       = r_state;
        n_table_ready = r_table_ready;
        cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_reseed || !r_table_ready) begin
                        cmd.load_seed = 1'b1;
                        n_state       = S_FILL;
                    end else begin
                        cmd.draw_rd = 1'b1;
                        n_state     = S_DWR;
                    end
                end
            end
            S_FILL: begin
                cmd.fill_step = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                cmd.pass_rd = 1'b1;
                n_state     = S_PWR;
            end
            S_PWR: begin
                cmd.pass_wr = 1'b1;
                if (i_sts.pass_last) begin
                    n_table_ready = 1'b1;
                    n_state       = S_DRD;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_DRD: begin
                cmd.draw_rd = 1'b1;
                n_state     = S_DWR;
            end
            S_DWR: begin
                // The table update and the result load wait for a free output slot.
                if (!r_rsp_valid || i_rsp_ready) begin
                    cmd.draw_wr = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.draw_wr) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end else begin
            n_rsp_valid = r_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_table_ready <= 1'b0;
            r_rsp_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_table_ready <= n_table_ready;
            r_rsp_valid   <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_cmd       = cmd;

endmodule

[hw/rtl/srg_dpath.sv]
// ----------------------------------------------------------------------------
// srg_dpath
// Lag table memory, seed register, index counters and the modular subtractor.
// ----------------------------------------------------------------------------
module srg_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  srg_pkg::t_seed i_cfg_wdata,
    input  srg_pkg::t_cmd  i_cmd,
    output srg_pkg::t_sts  o_sts,
    output srg_pkg::t_word o_draw
);
    import srg_pkg::*;

    t_word r_mem [TABLE_LEN];
    t_word r_rd_a, r_rd_b;
    t_seed r_seed;
    t_word r_cur, n_cur;
    t_word r_nxt, n_nxt;
    t_idx  r_slot, n_slot;
    t_idx  r_fcnt, n_fcnt;
    t_idx  r_pa, n_pa;
    t_idx  r_pb, n_pb;
    logic [1:0] r_pass, n_pass;
    t_idx  r_read_idx, n_read_idx;
    t_idx  r_lag_idx, n_lag_idx;
    t_word r_draw;

    t_word seed_red;
    t_word diff;
    t_idx  rd_addr_a, rd_addr_b;
    t_idx  wr_addr;
    t_word wr_data;
    logic  wr_en;
    logic [IDX_BITS:0] slot_sum;

    assign seed_red = (r_seed >= SEED_MOD) ? t_word'(r_seed - SEED_MOD) : t_word'(r_seed);
    assign diff     = mod_sub(r_rd_a, r_rd_b);
    assign slot_sum = {1'b0, r_slot} + {1'b0, FILL_STRIDE};

    // Read addresses; during the draw write cycle they hold the current draw indices.
    always_comb begin
        if (i_cmd.draw_rd) begin
            rd_addr_a = n_read_idx - t_idx'(1);
            rd_addr_b = n_lag_idx - t_idx'(1);
        end else if (i_cmd.pass_rd) begin
            rd_addr_a = r_pa;
            rd_addr_b = r_pb;
        end else begin
            rd_addr_a = r_read_idx - t_idx'(1);
            rd_addr_b = r_lag_idx - t_idx'(1);
        end
    end

    always_comb begin
        wr_en   = i_cmd.load_seed | i_cmd.fill_step | i_cmd.pass_wr | i_cmd.draw_wr;
        wr_addr = r_read_idx - t_idx'(1);
        wr_data = diff;
        if (i_cmd.load_seed) begin
            wr_addr = LAST_ADDR;
            wr_data = seed_red;
        end else if (i_cmd.fill_step) begin
            wr_addr = r_slot - t_idx'(1);
            wr_data = r_nxt;
        end else if (i_cmd.pass_wr) begin
            wr_addr = r_pa;
        end
    end

    always_comb begin
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_slot     = r_slot;
        n_fcnt     = r_fcnt;
        n_pa       = r_pa;
        n_pb       = r_pb;
        n_pass     = r_pass;
        n_read_idx = r_read_idx;
        n_lag_idx  = r_lag_idx;
        if (i_cmd.load_seed) begin
            n_cur      = seed_red;
            n_nxt      = t_word'(1);
            n_slot     = FILL_STRIDE;
            n_fcnt     = t_idx'(1);
            n_pa       = t_idx'(0);
            n_pb       = LAG_START;
            n_pass     = 2'd0;
            n_read_idx = t_idx'(0);
            n_lag_idx  = LAG_START;
        end
        if (i_cmd.fill_step) begin
            n_cur  = r_nxt;
            n_nxt  = mod_sub(r_cur, r_nxt);
            n_fcnt = r_fcnt + t_idx'(1);
            if (slot_sum >= (IDX_BITS+1)'(TABLE_LEN)) begin
                n_slot = t_idx'(slot_sum - (IDX_BITS+1)'(TABLE_LEN));
            end else begin
                n_slot = slot_sum[IDX_BITS-1:0];
            end
        end
        if (i_cmd.pass_wr) begin
            n_pa = (r_pa == LAST_ADDR) ? t_idx'(0) : r_pa + t_idx'(1);
            n_pb = (r_pb == LAST_ADDR) ? t_idx'(0) : r_pb + t_idx'(1);
            if (r_pa == LAST_ADDR) begin
                n_pass = r_pass + 2'd1;
            end
        end
        if (i_cmd.draw_rd) begin
            n_read_idx = next_idx(r_read_idx);
            n_lag_idx  = next_idx(r_lag_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= SEED_RESET;
            r_read_idx <= t_idx'(0);
            r_lag_idx  <= LAG_START;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            r_read_idx <= n_read_idx;
            r_lag_idx  <= n_lag_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_nxt  <= n_nxt;
        r_slot <= n_slot;
        r_fcnt <= n_fcnt;
        r_pa   <= n_pa;
        r_pb   <= n_pb;
        r_pass <= n_pass;
        if (i_cmd.draw_wr) begin
            r_draw <= diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    assign o_sts.fill_last = (r_fcnt == FILL_LAST);
    assign o_sts.pass_last = (r_pa == LAST_ADDR) && (r_pass == 2'd3);
    assign o_draw          = r_draw;

endmodule

[hw/rtl/subtractive_random_generator.sv]
// A normal draw reads the table, then writes back and loads the result once the
// output slot is free; o_rsp.valid is registered from that load.
// A new request is accepted only in idle, after the previous write-back.
// A reseed, and the first request after reset, first builds the table:
// a seed load, 54 fill writes and 4 x 55 lag steps (a read then a write each).
// Reset (synchronous, active low) clears the sequencer, the indices and the
// output valid, and restores the seed register; the table is rebuilt on demand.
// ----------------------------------------------------------------------------
// subtractive_random_generator
// Lagged subtractive random generator with a 55-word table.
// ----------------------------------------------------------------------------
`include "subtractive_random_generator_assert.svh"

module subtractive_random_generator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  srg_pkg::t_seed i_cfg_wdata,
    srg_req_if.sink        i_req,
    srg_rsp_if.source      o_rsp
);
    import srg_pkg::*;

    t_cmd       cmd;
    t_sts       sts;
    logic [3:0] wr_sel;

    srg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req.valid),
        .i_req_reseed (i_req.reseed),
        .o_req_ready  (i_req.ready),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_valid  (o_rsp.valid),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    srg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_draw      (o_rsp.draw)
    );

    assign wr_sel = {cmd.load_seed, cmd.fill_step, cmd.pass_wr, cmd.draw_wr};

    // Only one source may write the table in a cycle.
    `SRG_ASSERT_NOW(a_one_writer, $onehot0(wr_sel), "two table writes in one cycle")
    // A result is loaded only when the output slot is free.
    `SRG_ASSERT_NOW(a_no_overwrite, !cmd.draw_wr || !o_rsp.valid || o_rsp.ready, "result lost")
    // No request is taken while the table is being built.
    `SRG_ASSERT_NOW(a_busy_build, !(i_req.ready && (cmd.fill_step || cmd.pass_wr)), "accept in build")
    // A draw read is always followed by a cycle that does not accept a request.
    `SRG_ASSERT_NEXT(a_draw_busy, cmd.draw_rd, !i_req.ready, "accept during draw")

endmodule

[tb/tb_subtractive_random_generator.sv]
// ----------------------------------------------------------------------------
// tb_subtractive_random_generator
// Drives draw requests with random reseeds, seed register writes and random
// idling on both channels. A local model of the 55-word lagged table predicts
// every draw, and each response beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_subtractive_random_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import srg_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [63:0] MOD64       = 64'(MODULUS);
    localparam logic [63:0] SEED_ALL1   = 64'h3_FFFF_FFFF;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_cfg_we;
    t_seed i_cfg_wdata;

    srg_req_if req_bus ();
    srg_rsp_if rsp_bus ();

    subtractive_random_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    // Model state.
    t_word       model_table [1:55];
    logic [5:0]  model_read_idx;
    logic [5:0]  model_lag_idx;
    bit          model_built;
    logic [33:0] model_seed;

    t_word expected_draws [$];
    int    mismatch_count;
    int    idle_cycles;
    bit    no_idle;
    bit    hold_pending;

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    function automatic t_word mod_diff(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = (a >= b) ? (a - b) : (a + MOD64 - b);
        return t_word'(r);
    endfunction

    function automatic logic [5:0] advance_index(input logic [5:0] idx);
        logic [5:0] n;
        n = idx + 6'd1;
        if (n >= IDX_WRAP || n == 6'd0) begin
            n = 6'd1;
        end
        return n;
    endfunction

    function automatic void build_model_table();
        logic [63:0] cur;
        logic [63:0] nxt;
        logic [63:0] tmp;
        int          slot;
        cur = {30'd0, model_seed} % MOD64;
        nxt = 64'd1;
        model_table[55] = t_word'(cur);
        // Fill in the 21*i mod 55 order, each word the difference of the two before.
        for (int i = 1; i <= 54; i++) begin
            slot = (21 * i) % 55;
            model_table[slot] = t_word'(nxt);
            tmp = 64'(mod_diff(cur, nxt));
            cur = nxt;
            nxt = tmp;
        end
        for (int pass = 0; pass < 4; pass++) begin
            for (int i = 1; i <= 55; i++) begin
                model_table[i] = mod_diff(64'(model_table[i]),
                                          64'(model_table[1 + (i + 30) % 55]));
            end
        end
        model_read_idx = 6'd0;
        model_lag_idx  = LAG_START;
        model_built    = 1'b1;
    endfunction

    function automatic t_word predict_draw(input bit reseed);
        t_word v;
        if (reseed || !model_built) begin
            build_model_table();
        end
        model_read_idx = advance_index(model_read_idx);
        model_lag_idx  = advance_index(model_lag_idx);
        v = mod_diff(64'(model_table[model_read_idx]) % MOD64,
                     64'(model_table[model_lag_idx]) % MOD64);
        model_table[model_read_idx] = v;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        if (mismatch_count < 40) begin
            $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // One request beat; the predictor runs at the edge that accepts it.
    task automatic send_request(input bit reseed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.reseed <= reseed;
        do @(posedge i_clk); while (!req_bus.ready);
        expected_draws.push_back(predict_draw(reseed));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_draws.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_seed'(value);
        @(posedge i_clk);
        model_seed = value[33:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Receiver: random ready gaps, plus one long hold-off on request.
    initial begin
        int gap;
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_pending) begin
                gap = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (gap != 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_draws.size() == 0) begin
                report_mismatch("unexpected draw", rsp_bus.draw, '0);
            end else begin
                if (rsp_bus.draw !== expected_draws[0]) begin
                    report_mismatch("draw", rsp_bus.draw, expected_draws[0]);
                end
                void'(expected_draws.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // The table is built by the first request even with reseed low.
    task automatic test_first_request();
        send_request(1'b0);
        repeat (4) send_request(1'b0);
    endtask

    // Reseeding restarts the sequence from the same seed.
    task automatic test_reseed_restart();
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Seeds at the bounds, at the modulus and with every bit set.
    task automatic test_seed_extremes();
        logic [63:0] seeds [4];
        seeds = '{64'd0, MOD64 - 64'd1, MOD64, SEED_ALL1};
        foreach (seeds[k]) begin
            wait_drained();
            write_seed(seeds[k]);
            send_request(1'b1);
            send_request(1'b0);
            send_request(1'b0);
        end
        // A new seed has no effect until the next reseed.
        wait_drained();
        write_seed(64'd127384609);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Long receiver hold-off while requests keep coming back to back.
    task automatic test_backpressure();
        wait_drained();
        no_idle = 1'b1;
        hold_pending = 1'b1;
        repeat (30) send_request(1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_random_draws();
        logic [63:0] seed;
        int          count;
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            case ($urandom_range(0, 5))
                0: begin
                    seed = 64'd0;
                end
                1: begin
                    seed = MOD64 - 64'd1;
                end
                2: begin
                    seed = SEED_ALL1;
                end
                default: begin
                    seed = {30'd0, 2'($urandom_range(0, 3)), $urandom};
                end
            endcase
            write_seed(seed);
            count = $urandom_range(150, 190);
            for (int n = 0; n < count; n++) begin
                // Stretches without idling on either side.
                if (n % 40 == 0) begin
                    no_idle = ($urandom_range(0, 3) == 0);
                end
                send_request(n == 0 || $urandom_range(0, 31) == 0);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        req_bus.valid  = 1'b0;
        req_bus.reseed = 1'b0;
        mismatch_count = 0;
        no_idle        = 1'b0;
        hold_pending   = 1'b0;
        model_seed     = SEED_RESET;
        model_built    = 1'b0;
        model_read_idx = 6'd0;
        model_lag_idx  = LAG_START;
        foreach (model_table[k]) begin
            model_table[k] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_request();
        test_reseed_restart();
        test_seed_extremes();
        test_backpressure();
        test_random_draws();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
